### sv/bounded_fifo_with_head_eviction_assert.svh
// Assertion macros for the bounded FIFO with head eviction.
`ifndef BOUNDED_FIFO_WITH_HEAD_EVICTION_ASSERT_SVH
`define BOUNDED_FIFO_WITH_HEAD_EVICTION_ASSERT_SVH

`ifndef SYNTHESIS
// Checked property with reset disable.
`define BFHE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked property that holds during reset as well.
`define BFHE_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BFHE_ASSERT(label, clk, rst_n, prop, msg)
`define BFHE_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

### sv/bfhe_pkg.sv
// Shared constants, codes and types of the bounded FIFO with head eviction.
`timescale 1ns / 1ps
package bfhe_pkg;

    localparam int DEPTH      = 32;
    localparam int DATA_WIDTH = 32;
    localparam int AW         = $clog2(DEPTH);
    localparam int FW         = $clog2(DEPTH + 1);
    localparam int REQ_W      = 4;
    localparam int PAYLOAD_W  = 32;
    localparam int STATUS_W   = 3;
    localparam int ITEM_W     = 32;
    localparam int COUNT_W    = 6;
    localparam int CFG_W      = 6;

    localparam logic [REQ_W-1:0] REQ_OFFER       = 4'd0;
    localparam logic [REQ_W-1:0] REQ_OFFER_EVICT = 4'd1;
    localparam logic [REQ_W-1:0] REQ_PEEK        = 4'd2;
    localparam logic [REQ_W-1:0] REQ_POLL        = 4'd3;
    localparam logic [REQ_W-1:0] REQ_TAKE        = 4'd4;
    localparam logic [REQ_W-1:0] REQ_FLUSH       = 4'd5;
    localparam logic [REQ_W-1:0] REQ_SHUTDOWN    = 4'd6;
    localparam logic [REQ_W-1:0] REQ_DRAIN       = 4'd7;
    localparam logic [REQ_W-1:0] REQ_WAKE        = 4'd8;
    localparam logic [REQ_W-1:0] REQ_COUNT       = 4'd9;

    localparam logic [STATUS_W-1:0] ST_SUCCESS     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INTERRUPTED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BOUND       = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_ELEMENT  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_USER_WAKE   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_WAITER_BUSY = 3'd5;

    typedef enum logic {
        FSM_IDLE,
        FSM_EXEC
    } ctrl_state_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ITEM_W-1:0]   item_data;
        logic                evicted;
        logic [COUNT_W-1:0]  count;
        logic                for_waiter;
        logic                last;
    } result_t;

    typedef struct packed {
        logic    valid;
        logic    two;
        result_t r0;
        result_t r1;
    } push_t;

endpackage

### sv/bounded_fifo_with_head_eviction.sv
// Top level of the bounded FIFO with head eviction.
`timescale 1ns / 1ps
// Bounded FIFO of DATA_WIDTH-bit words held in a single-port-pair RAM, with
// offer, evicting offer, peek, poll, blocking take, flush, shutdown, drain,
// user wake and count requests. Accepting a request in the idle state starts
// the registered read of the head slot; the execute state then updates
// pointers and flags and writes the tail slot, and no new request is taken
// until it is done. A request yields zero, one or two result beats (the
// second answers a parked take, with for_waiter set); these sit in a two-entry
// buffer and leave one per cycle while m_tready is high, and the execute state
// of the next request waits until that buffer is empty. Storage needs no
// clearing pass after reset. Write size_bound only while no request is in flight.
module bounded_fifo_with_head_eviction import bfhe_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [CFG_W-1:0]  cfg_wr_data,   // size_bound
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,       // payload[31:0]
    input  logic [3:0]        s_tuser,       // req_type[3:0]
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [39:0]       m_tdata,       // item_data[31:0], count[37:32], zero pad
    output logic [4:0]        m_tuser,       // status[2:0], evicted[3], for_waiter[4]
    output logic              m_tlast
);

    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic                  outq_empty;
    push_t                 push;
    result_t               head;

    bfhe_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_slots (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bfhe_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_tvalid),
        .s_ready     (s_tready),
        .req_type    (s_tuser[REQ_W-1:0]),
        .payload     (s_tdata[PAYLOAD_W-1:0]),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .outq_empty  (outq_empty),
        .push        (push)
    );

    bfhe_outq u_outq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .empty   (outq_empty),
        .head    (head),
        .m_valid (m_tvalid),
        .m_ready (m_tready)
    );

    assign m_tdata = {2'b00, head.count, head.item_data};
    assign m_tuser = {head.for_waiter, head.evicted, head.status};
    assign m_tlast = head.last;

endmodule

### sv/bfhe_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bfhe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### sv/bfhe_outq.sv
// Two-entry result buffer that feeds the master-side stream.
`timescale 1ns / 1ps
module bfhe_outq import bfhe_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  push_t   push,
    output logic    empty,
    output result_t head,
    output logic    m_valid,
    input  logic    m_ready
);

    logic [1:0] cnt_reg, cnt_next;
    result_t    q0_reg, q0_next;
    result_t    q1_reg, q1_next;

    always_comb begin
        cnt_next = cnt_reg;
        q0_next  = q0_reg;
        q1_next  = q1_reg;
        if (push.valid) begin
            // a push only comes while the buffer is empty
            q0_next  = push.r0;
            q1_next  = push.r1;
            cnt_next = push.two ? 2'd2 : 2'd1;
        end else if (m_valid && m_ready) begin
            q0_next  = q1_reg;
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

    assign empty   = (cnt_reg == 2'd0);
    assign m_valid = !empty;
    assign head    = q0_reg;

endmodule

### sv/bfhe_ctrl.sv
// Queue controller: pointers, flags, request decode and waiter handling.
`timescale 1ns / 1ps
module bfhe_ctrl import bfhe_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [REQ_W-1:0]      req_type,
    input  logic [PAYLOAD_W-1:0]  payload,
    input  logic                  cfg_wr_en,
    input  logic [CFG_W-1:0]      cfg_wr_data,
    output logic                  ram_re,
    output logic [AW-1:0]         ram_raddr,
    input  logic [DATA_WIDTH-1:0] ram_rdata,
    output logic                  ram_we,
    output logic [AW-1:0]         ram_waddr,
    output logic [DATA_WIDTH-1:0] ram_wdata,
    input  logic                  outq_empty,
    output push_t                 push
);

`include "bounded_fifo_with_head_eviction_assert.svh"

    ctrl_state_t state_reg, state_next;

    logic [AW-1:0]         head_reg, head_next;
    logic [AW-1:0]         tail_reg, tail_next;
    logic [FW-1:0]         fill_reg, fill_next;
    logic                  shut_reg, shut_next;
    logic                  drain_reg, drain_next;
    logic                  wake_reg, wake_next;
    logic                  waiter_reg, waiter_next;
    logic [CFG_W-1:0]      bound_reg;
    logic [REQ_W-1:0]      req_reg;
    logic [DATA_WIDTH-1:0] data_reg;

    logic          go;
    logic          accept;
    logic [FW-1:0] cap;

    function automatic logic [AW-1:0] inc_ptr(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    function automatic result_t mk_res(input logic [STATUS_W-1:0] st,
                                       input logic [DATA_WIDTH-1:0] d,
                                       input logic ev,
                                       input logic [FW-1:0] cnt,
                                       input logic fw);
        result_t r;
        r.status     = st;
        r.item_data  = ITEM_W'(d);
        r.evicted    = ev;
        r.count      = COUNT_W'(cnt);
        r.for_waiter = fw;
        r.last       = 1'b0;
        return r;
    endfunction

    assign accept    = s_valid && s_ready;
    assign go        = (state_reg == FSM_EXEC) && outq_empty;
    assign s_ready   = (state_reg == FSM_IDLE);
    assign ram_re    = accept;
    assign ram_raddr = head_reg;
    assign ram_waddr = tail_reg;
    assign ram_wdata = data_reg;

    // a bound of zero or above the depth means the full depth
    assign cap = (bound_reg == '0 || 32'(bound_reg) > DEPTH) ? FW'(DEPTH) : FW'(bound_reg);

    always_comb begin
        logic    may_wake;
        logic    n0;
        logic    do_push;
        result_t r0;
        result_t r1;

        state_next  = state_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        fill_next   = fill_reg;
        shut_next   = shut_reg;
        drain_next  = drain_reg;
        wake_next   = wake_reg;
        waiter_next = waiter_reg;
        may_wake    = 1'b0;
        n0          = 1'b0;
        do_push     = 1'b0;
        r0          = '0;
        r1          = '0;
        push        = '0;

        case (state_reg)
            FSM_IDLE: begin
                if (accept) begin
                    state_next = FSM_EXEC;
                end
            end
            FSM_EXEC: begin
                if (go) begin
                    state_next = FSM_IDLE;
                    n0         = 1'b1;
                    case (req_reg)
                        REQ_OFFER, REQ_OFFER_EVICT: begin
                            may_wake = 1'b1;
                            if (shut_reg || drain_reg) begin
                                r0 = mk_res(ST_INTERRUPTED, '0, 1'b0, fill_reg, 1'b0);
                            end else if (fill_reg >= cap) begin
                                if (req_reg == REQ_OFFER) begin
                                    r0 = mk_res(ST_BOUND, '0, 1'b0, fill_reg, 1'b0);
                                end else begin
                                    // drop the head, append; fill stays
                                    head_next = inc_ptr(head_reg);
                                    tail_next = inc_ptr(tail_reg);
                                    do_push   = 1'b1;
                                    r0 = mk_res(ST_SUCCESS, ram_rdata, 1'b1, fill_reg, 1'b0);
                                end
                            end else begin
                                tail_next = inc_ptr(tail_reg);
                                fill_next = fill_reg + FW'(1);
                                do_push   = 1'b1;
                                r0 = mk_res(ST_SUCCESS, '0, 1'b0, fill_reg + FW'(1), 1'b0);
                            end
                        end
                        REQ_PEEK, REQ_POLL: begin
                            if (shut_reg) begin
                                r0 = mk_res(ST_INTERRUPTED, '0, 1'b0, fill_reg, 1'b0);
                            end else if (fill_reg == '0) begin
                                r0 = mk_res(drain_reg ? ST_INTERRUPTED : ST_NO_ELEMENT,
                                            '0, 1'b0, '0, 1'b0);
                            end else if (req_reg == REQ_PEEK) begin
                                r0 = mk_res(ST_SUCCESS, ram_rdata, 1'b0, fill_reg, 1'b0);
                            end else begin
                                head_next = inc_ptr(head_reg);
                                fill_next = fill_reg - FW'(1);
                                r0 = mk_res(ST_SUCCESS, ram_rdata, 1'b0,
                                            fill_reg - FW'(1), 1'b0);
                            end
                        end
                        REQ_TAKE: begin
                            if (waiter_reg) begin
                                r0 = mk_res(ST_WAITER_BUSY, '0, 1'b0, fill_reg, 1'b0);
                            end else if (shut_reg) begin
                                r0 = mk_res(ST_INTERRUPTED, '0, 1'b0, fill_reg, 1'b0);
                            end else if (wake_reg) begin
                                wake_next = 1'b0;
                                r0 = mk_res(ST_USER_WAKE, '0, 1'b0, fill_reg, 1'b0);
                            end else if (fill_reg != '0) begin
                                head_next = inc_ptr(head_reg);
                                fill_next = fill_reg - FW'(1);
                                r0 = mk_res(ST_SUCCESS, ram_rdata, 1'b0,
                                            fill_reg - FW'(1), 1'b0);
                            end else if (drain_reg) begin
                                r0 = mk_res(ST_INTERRUPTED, '0, 1'b0, fill_reg, 1'b0);
                            end else begin
                                // park as the waiter, no beat
                                waiter_next = 1'b1;
                                n0          = 1'b0;
                            end
                        end
                        REQ_FLUSH: begin
                            head_next = '0;
                            tail_next = '0;
                            fill_next = '0;
                            r0 = mk_res(ST_SUCCESS, '0, 1'b0, fill_reg, 1'b0);
                        end
                        REQ_SHUTDOWN, REQ_DRAIN, REQ_WAKE: begin
                            if (req_reg == REQ_SHUTDOWN) begin
                                shut_next = 1'b1;
                            end else if (req_reg == REQ_DRAIN) begin
                                drain_next = 1'b1;
                            end else begin
                                wake_next = 1'b1;
                            end
                            may_wake = 1'b1;
                            r0 = mk_res(ST_SUCCESS, '0, 1'b0, fill_reg, 1'b0);
                        end
                        REQ_COUNT: begin
                            r0 = mk_res(ST_SUCCESS, '0, 1'b0, fill_reg, 1'b0);
                        end
                        default: begin
                            n0 = 1'b0;
                        end
                    endcase

                    push.valid = n0;
                    push.r0    = r0;
                    push.r0.last = 1'b1;

                    // answer the waiter once the request made it ready
                    if (may_wake && waiter_reg &&
                        (fill_next != '0 || drain_next || shut_next || wake_next)) begin
                        waiter_next = 1'b0;
                        if (shut_next) begin
                            r1 = mk_res(ST_INTERRUPTED, '0, 1'b0, fill_next, 1'b1);
                        end else if (wake_next) begin
                            wake_next = 1'b0;
                            r1 = mk_res(ST_USER_WAKE, '0, 1'b0, fill_next, 1'b1);
                        end else if (fill_next == '0) begin
                            r1 = mk_res(ST_INTERRUPTED, '0, 1'b0, fill_next, 1'b1);
                        end else begin
                            // a pending waiter means the queue was empty, so the
                            // new head is the word just pushed
                            head_next = inc_ptr(head_next);
                            r1 = mk_res(ST_SUCCESS, data_reg, 1'b0,
                                        fill_next - FW'(1), 1'b1);
                            fill_next = fill_next - FW'(1);
                        end
                        r1.last      = 1'b1;
                        push.r0.last = 1'b0;
                        push.r1      = r1;
                        push.two     = 1'b1;
                    end
                end
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase

        ram_we = do_push;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= FSM_IDLE;
            head_reg   <= '0;
            tail_reg   <= '0;
            fill_reg   <= '0;
            shut_reg   <= 1'b0;
            drain_reg  <= 1'b0;
            wake_reg   <= 1'b0;
            waiter_reg <= 1'b0;
            bound_reg  <= '0;
        end else begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            fill_reg   <= fill_next;
            shut_reg   <= shut_next;
            drain_reg  <= drain_next;
            wake_reg   <= wake_next;
            waiter_reg <= waiter_next;
            if (cfg_wr_en) begin
                bound_reg <= cfg_wr_data;
            end
        end
        if (accept) begin
            req_reg  <= req_type;
            data_reg <= payload[DATA_WIDTH-1:0];
        end
    end

    `BFHE_ASSERT(a_fill_in_range, aclk, aresetn, fill_reg <= FW'(DEPTH), "fill above depth")
    `BFHE_ASSERT(a_waiter_idle_queue, aclk, aresetn, waiter_reg |-> (fill_reg == '0 && !shut_reg && !drain_reg && !wake_reg), "waiter pending on a ready queue")
    `BFHE_ASSERT(a_push_on_empty, aclk, aresetn, push.valid |-> outq_empty, "result push into busy buffer")
    `BFHE_ASSERT(a_exec_after_accept, aclk, aresetn, accept |=> (state_reg == FSM_EXEC), "accepted beat not executed")

endmodule

### tb/bounded_fifo_with_head_eviction_tb.sv
// Testbench for the bounded FIFO with head eviction: random and directed requests, scored beats.
`timescale 1ns / 1ps
module bounded_fifo_with_head_eviction_tb;
    import bfhe_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_WAIT  = 12;
    localparam int HOLD_CYCLES  = 400;
    localparam int MAX_PRINTED  = 50;

    localparam logic [REQ_W-1:0] REQ_UNUSED_LO = REQ_COUNT + 1'b1;
    localparam logic [REQ_W-1:0] REQ_UNUSED_HI = '1;

    typedef struct packed {
        logic [REQ_W-1:0]     req;
        logic [PAYLOAD_W-1:0] payload;
    } fifo_req_t;

    logic               aclk        = 1'b0;
    logic               aresetn     = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0]   cfg_wr_data = '0;
    logic               s_tvalid    = 1'b0;
    logic               s_tready;
    logic [31:0]        s_tdata     = '0;
    logic [3:0]         s_tuser     = '0;
    logic               m_tvalid;
    logic               m_tready    = 1'b0;
    logic [39:0]        m_tdata;
    logic [4:0]         m_tuser;
    logic               m_tlast;

    bounded_fifo_with_head_eviction u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    fifo_req_t   send_queue [$];
    result_t     owed_results [$];
    int unsigned fail_count   = 0;
    int unsigned items_sent   = 0;
    int unsigned beats_seen   = 0;
    int unsigned cycle_count  = 0;
    int unsigned bounds_used  = 0;
    logic        idle_on      = 1'b1;
    logic        hold_request = 1'b0;
    logic        hold_done    = 1'b0;
    logic        rx_hold      = 1'b0;
    int unsigned hold_left    = 0;
    int unsigned s_idle_left  = 0;
    int unsigned m_idle_left  = 0;

    // Shadow of the queue state.
    logic [31:0]        q_slots [0:DEPTH-1];
    logic [AW-1:0]      q_head     = '0;
    logic [AW-1:0]      q_tail     = '0;
    logic [COUNT_W-1:0] q_fill     = '0;
    logic               q_shutdown = 1'b0;
    logic               q_drain    = 1'b0;
    logic               q_wake     = 1'b0;
    logic               q_waiter   = 1'b0;
    logic [CFG_W-1:0]   q_bound    = '0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic [AW-1:0] step_index(input logic [AW-1:0] i);
        return (i == DEPTH - 1) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [31:0] pop_head();
        logic [31:0] d;
        d = q_slots[q_head];
        q_head = step_index(q_head);
        q_fill = q_fill - 1'b1;
        return d;
    endfunction

    task automatic push_tail(input logic [31:0] d);
        q_slots[q_tail] = d;
        q_tail = step_index(q_tail);
        q_fill = q_fill + 1'b1;
    endtask

    function automatic logic take_is_ready();
        return (q_fill != 0) || q_drain || q_shutdown || q_wake;
    endfunction

    task automatic take_head(output logic [STATUS_W-1:0] st, output logic [31:0] d);
        d = '0;
        if (q_shutdown) begin
            st = ST_INTERRUPTED;
        end else if (q_wake) begin
            q_wake = 1'b0;
            st = ST_USER_WAKE;
        end else if (q_fill == 0) begin
            st = ST_INTERRUPTED;
        end else begin
            d = pop_head();
            st = ST_SUCCESS;
        end
    endtask

    function automatic result_t make_result(input logic [STATUS_W-1:0] st,
                                            input logic [31:0] d, input logic ev,
                                            input logic [COUNT_W-1:0] cnt,
                                            input logic fw);
        result_t r;
        r.status     = st;
        r.item_data  = d;
        r.evicted    = ev;
        r.count      = cnt;
        r.for_waiter = fw;
        r.last       = 1'b0;
        return r;
    endfunction

    // Advance the shadow queue by one request and queue the beats it owes.
    task automatic run_fifo_request(input logic [REQ_W-1:0] req, input logic [31:0] word);
        result_t             res [0:1];
        int                  n;
        int                  cap;
        logic                may_wake;
        logic [31:0]         d;
        logic [STATUS_W-1:0] st;
        logic [COUNT_W-1:0]  flushed;
        n = 0;
        may_wake = 1'b0;
        cap = (q_bound == 0 || q_bound > DEPTH) ? DEPTH : q_bound;
        case (req)
            REQ_OFFER, REQ_OFFER_EVICT: begin
                may_wake = 1'b1;
                if (q_shutdown || q_drain) begin
                    res[n] = make_result(ST_INTERRUPTED, '0, 1'b0, q_fill, 1'b0); n++;
                end else if (q_fill >= cap) begin
                    if (req == REQ_OFFER) begin
                        res[n] = make_result(ST_BOUND, '0, 1'b0, q_fill, 1'b0); n++;
                    end else begin
                        d = pop_head();
                        push_tail(word);
                        res[n] = make_result(ST_SUCCESS, d, 1'b1, q_fill, 1'b0); n++;
                    end
                end else begin
                    push_tail(word);
                    res[n] = make_result(ST_SUCCESS, '0, 1'b0, q_fill, 1'b0); n++;
                end
            end
            REQ_PEEK, REQ_POLL: begin
                if (q_shutdown) begin
                    res[n] = make_result(ST_INTERRUPTED, '0, 1'b0, q_fill, 1'b0); n++;
                end else if (q_fill == 0) begin
                    res[n] = make_result(q_drain ? ST_INTERRUPTED : ST_NO_ELEMENT, '0, 1'b0,
                                         '0, 1'b0);
                    n++;
                end else begin
                    d = (req == REQ_PEEK) ? q_slots[q_head] : pop_head();
                    res[n] = make_result(ST_SUCCESS, d, 1'b0, q_fill, 1'b0); n++;
                end
            end
            REQ_TAKE: begin
                if (q_waiter) begin
                    res[n] = make_result(ST_WAITER_BUSY, '0, 1'b0, q_fill, 1'b0); n++;
                end else if (!take_is_ready()) begin
                    q_waiter = 1'b1;
                end else begin
                    take_head(st, d);
                    res[n] = make_result(st, d, 1'b0, q_fill, 1'b0); n++;
                end
            end
            REQ_FLUSH: begin
                flushed = q_fill;
                q_fill = '0;
                q_head = '0;
                q_tail = '0;
                res[n] = make_result(ST_SUCCESS, '0, 1'b0, flushed, 1'b0); n++;
            end
            REQ_SHUTDOWN, REQ_DRAIN, REQ_WAKE: begin
                if (req == REQ_SHUTDOWN) q_shutdown = 1'b1;
                else if (req == REQ_DRAIN) q_drain = 1'b1;
                else q_wake = 1'b1;
                may_wake = 1'b1;
                res[n] = make_result(ST_SUCCESS, '0, 1'b0, q_fill, 1'b0); n++;
            end
            REQ_COUNT: begin
                res[n] = make_result(ST_SUCCESS, '0, 1'b0, q_fill, 1'b0); n++;
            end
            default: begin
            end
        endcase
        // Answer the parked take once this request has made it ready.
        if (may_wake && q_waiter && take_is_ready()) begin
            q_waiter = 1'b0;
            take_head(st, d);
            res[n] = make_result(st, d, 1'b0, q_fill, 1'b1); n++;
        end
        if (n > 0) res[n-1].last = 1'b1;
        for (int i = 0; i < n; i++) owed_results.push_back(res[i]);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        fail_count++;
        if (fail_count <= MAX_PRINTED)
            $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    endtask

    task automatic check_result_beat();
        result_t want;
        beats_seen++;
        if (owed_results.size() == 0) begin
            report_mismatch("unexpected result beat", {27'd0, m_tuser}, 32'd0);
        end else begin
            want = owed_results.pop_front();
            if (m_tuser[2:0] !== want.status)
                report_mismatch("status", 32'(m_tuser[2:0]), 32'(want.status));
            if (m_tdata[31:0] !== want.item_data)
                report_mismatch("item_data", m_tdata[31:0], want.item_data);
            if (m_tuser[3] !== want.evicted)
                report_mismatch("evicted", 32'(m_tuser[3]), 32'(want.evicted));
            if (m_tdata[37:32] !== want.count)
                report_mismatch("count", 32'(m_tdata[37:32]), 32'(want.count));
            if (m_tuser[4] !== want.for_waiter)
                report_mismatch("for_waiter", 32'(m_tuser[4]), 32'(want.for_waiter));
            if (m_tlast !== want.last)
                report_mismatch("tlast", 32'(m_tlast), 32'(want.last));
            if (m_tdata[39:38] !== 2'b00)
                report_mismatch("tdata pad", 32'(m_tdata[39:38]), 32'd0);
        end
    endtask

    // Request driver: one beat in flight, random gaps between beats.
    always @(posedge aclk) begin : drive_proc
        fifo_req_t it;
        if (!aresetn) begin
            s_tvalid    <= 1'b0;
            s_idle_left <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                run_fifo_request(s_tuser, s_tdata);
                items_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (s_idle_left != 0) begin
                    s_idle_left <= s_idle_left - 1;
                    s_tvalid    <= 1'b0;
                end else if (send_queue.size() != 0 && idle_on && $urandom_range(0, 5) == 0) begin
                    s_idle_left <= $urandom_range(0, 16);
                    s_tvalid    <= 1'b0;
                end else if (send_queue.size() != 0) begin
                    it = send_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= it.req;
                    s_tdata  <= it.payload;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, started once on request.
    always @(posedge aclk) begin : hold_proc
        if (!aresetn) begin
            hold_left <= 0;
            rx_hold   <= 1'b0;
            hold_done <= 1'b0;
        end else if (hold_request && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            rx_hold   <= 1'b1;
            hold_done <= 1'b1;
        end else if (hold_left > 1) begin
            hold_left <= hold_left - 1;
        end else begin
            hold_left <= 0;
            rx_hold   <= 1'b0;
        end
    end

    // Result sink and scoreboard.
    always @(posedge aclk) begin : sink_proc
        if (!aresetn) begin
            m_tready    <= 1'b0;
            m_idle_left <= 0;
        end else begin
            if (m_tvalid && m_tready) check_result_beat();
            if (rx_hold) begin
                m_tready <= 1'b0;
            end else if (m_idle_left != 0) begin
                m_idle_left <= m_idle_left - 1;
                m_tready    <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                m_idle_left <= $urandom_range(0, 16);
                m_tready    <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : watchdog_proc
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still owed", $realtime, owed_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send(input logic [REQ_W-1:0] req, input logic [31:0] word);
        fifo_req_t it;
        it.req     = req;
        it.payload = word;
        send_queue.push_back(it);
    endtask

    // Hold until every beat is sent and answered, then let the pipeline empty.
    // Sample on the falling edge so the driver's updates have all landed.
    task automatic settle();
        while (send_queue.size() != 0 || s_tvalid || owed_results.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_WAIT) @(posedge aclk);
    endtask

    task automatic write_bound(input logic [CFG_W-1:0] v);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        q_bound = v;
        bounds_used++;
    endtask

    function automatic fifo_req_t pick_request(input int unsigned offer_pct);
        fifo_req_t   it;
        int unsigned r;
        it.payload = $urandom;
        r = $urandom_range(0, 99);
        if (r < offer_pct) begin
            it.req = ($urandom_range(0, 2) == 0) ? REQ_OFFER_EVICT : REQ_OFFER;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 18)      it.req = REQ_PEEK;
            else if (r < 50) it.req = REQ_POLL;
            else if (r < 75) it.req = REQ_TAKE;
            else if (r < 79) it.req = REQ_FLUSH;
            else if (r < 85) it.req = REQ_WAKE;
            else if (r < 95) it.req = REQ_COUNT;
            else             it.req = REQ_W'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
        end
        return it;
    endfunction

    task automatic random_phase(input logic [CFG_W-1:0] bound, input int unsigned offer_pct,
                                input int unsigned n);
        write_bound(bound);
        @(negedge aclk);
        for (int i = 0; i < n; i++) send_queue.push_back(pick_request(offer_pct));
        settle();
    endtask

    initial begin : stimulus_proc
        fifo_req_t it;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part, bound of two.
        write_bound(6'd2);
        @(negedge aclk);
        send(REQ_PEEK, $urandom);
        send(REQ_POLL, $urandom);
        send(REQ_COUNT, $urandom);
        send(REQ_OFFER, 32'h0000_0000);
        send(REQ_OFFER, 32'hFFFF_FFFF);
        send(REQ_OFFER, 32'hA5A5_A5A5);          // refused at bound
        send(REQ_OFFER_EVICT, 32'h5A5A_5A5A);    // drops the head
        send(REQ_PEEK, $urandom);
        send(REQ_POLL, $urandom);
        send(REQ_TAKE, $urandom);
        send(REQ_TAKE, $urandom);                // parks as waiter
        send(REQ_TAKE, $urandom);                // waiter busy
        send(REQ_COUNT, $urandom);
        send(REQ_OFFER, 32'h1234_5678);          // answers the waiter
        send(REQ_WAKE, $urandom);
        send(REQ_TAKE, $urandom);                // consumes the wake
        send(REQ_TAKE, $urandom);
        send(REQ_WAKE, $urandom);                // wakes the parked take
        send(REQ_UNUSED_LO, $urandom);
        send(REQ_UNUSED_HI, $urandom);
        send(REQ_OFFER, $urandom);
        send(REQ_FLUSH, $urandom);
        send(REQ_FLUSH, $urandom);
        send(REQ_POLL, $urandom);
        settle();

        // Random part across bounds, including above depth and below the fill.
        hold_request <= 1'b1;
        random_phase(6'd0, 60, 100);
        random_phase(6'd1, 45, 80);
        random_phase(6'd63, 60, 100);
        random_phase(6'd32, 75, 90);
        random_phase(6'd3, 45, 80);
        random_phase(6'd4, 50, 80);
        random_phase(6'd40, 55, 80);
        idle_on <= 1'b0;
        random_phase(6'd0, 50, 80);

        // Sticky flags last: drain with data held, then shutdown.
        write_bound(6'd5);
        @(negedge aclk);
        for (int i = 0; i < 8; i++) send(($urandom_range(0, 1) == 0) ? REQ_OFFER : REQ_OFFER_EVICT,
                                         $urandom);
        send(REQ_DRAIN, $urandom);
        send(REQ_OFFER, $urandom);
        send(REQ_OFFER_EVICT, $urandom);
        send(REQ_PEEK, $urandom);
        send(REQ_POLL, $urandom);
        send(REQ_WAKE, $urandom);
        send(REQ_TAKE, $urandom);
        send(REQ_TAKE, $urandom);
        send(REQ_SHUTDOWN, $urandom);
        send(REQ_PEEK, $urandom);
        send(REQ_POLL, $urandom);
        send(REQ_TAKE, $urandom);
        send(REQ_WAKE, $urandom);
        send(REQ_TAKE, $urandom);
        send(REQ_FLUSH, $urandom);
        send(REQ_COUNT, $urandom);
        for (int i = 0; i < 12; i++) begin
            it = pick_request(30);
            send_queue.push_back(it);
        end
        settle();

        $display("Sent %0d requests over %0d size-bound settings; checked %0d result beats.",
                 items_sent, bounds_used, beats_seen);
        $display("Covered eviction, bound refusal, parked takes, wake, flush, drain and shutdown.");
        if (fail_count == 0 && owed_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+sv
sv/bfhe_pkg.sv
sv/bfhe_ram.sv
sv/bfhe_outq.sv
sv/bfhe_ctrl.sv
sv/bounded_fifo_with_head_eviction.sv
tb/bounded_fifo_with_head_eviction_tb.sv
